// ===== sv/m3e_pkg.sv =====
package m3e_pkg;

    // Sample and gain formats
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int VALUE_W        = 32;
    localparam int VALUE_FRAC     = 16;

    // Datapath widths
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int WIDE_W  = 64;

    // Configuration port
    localparam int CFG_DATA_W  = GAIN_W;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIAN_ENABLE  = CFG_INDEX_W'(1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << GAIN_FRAC_BITS;

    // Stream byte widths
    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [VALUE_W-1:0]      value_t;

    typedef struct packed {
        logic [GAIN_W-1:0] smoothing_gain;
        logic              median_enable;
    } cfg_t;

    // Clamp a wide signed value to the signed output range
    function automatic value_t sat_value(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] vmax;
        logic signed [WIDE_W-1:0] vmin;
        vmax = WIDE_W'({1'b0, {(VALUE_W-1){1'b1}}});
        vmin = -vmax - WIDE_W'(1);
        if (v > vmax) begin
            sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (v < vmin) begin
            sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            sat_value = v[VALUE_W-1:0];
        end
    endfunction

    // Sample to fixed point, saturated
    function automatic value_t sample_to_value(input sample_t s);
        logic signed [WIDE_W-1:0] w;
        w = {{(WIDE_W-SAMPLE_WIDTH){s[SAMPLE_WIDTH-1]}}, s};
        sample_to_value = sat_value(w <<< VALUE_FRAC);
    endfunction

endpackage

// ===== sv/median3_ema_filter.sv =====
// An input transfer enters in_valid_reg, then m_valid_reg with the average.
// Throughput: one sample per cycle unless m_tready stalls; the average
// register closes a loop via one 33x18 multiply, one add and a saturate.
// Reset (aresetn low, synchronous): pipeline empty, window and average zero,
// not primed, smoothing_gain = 1.0, median_enable = 1.
module median3_ema_filter
    import m3e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [31:0] filtered_value
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    in_valid_reg, in_valid_next;
    sample_t in_sample_reg, in_sample_next;
    logic    m_valid_reg, m_valid_next;
    logic    advance;
    value_t  average;

    m3e_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Output slot free or being drained this cycle
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        m_valid_next   = m_valid_reg;
        if (advance) begin
            m_valid_next  = in_valid_reg;
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next  = 1'b1;
            in_sample_next = s_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_sample_reg <= in_sample_next;
    end

    m3e_ema u_ema (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance && in_valid_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .average (average)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(average);

endmodule

// ===== sv/m3e_cfg.sv =====
module m3e_cfg
    import m3e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SMOOTHING_GAIN: cfg_next.smoothing_gain = cfg_data[GAIN_W-1:0];
                REG_MEDIAN_ENABLE:  cfg_next.median_enable  = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoothing_gain <= GAIN_RESET;
            cfg_reg.median_enable  <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/m3e_median.sv =====
module m3e_median
    import m3e_pkg::*;
(
    input  sample_t a,
    input  sample_t b,
    input  sample_t c,
    output sample_t mid
);

    sample_t lo_ab;
    sample_t hi_ab;
    sample_t lo_hc;

    // median = max(min(a,b), min(max(a,b),c))
    assign lo_ab = (a < b) ? a : b;
    assign hi_ab = (a < b) ? b : a;
    assign lo_hc = (hi_ab < c) ? hi_ab : c;
    assign mid   = (lo_ab > lo_hc) ? lo_ab : lo_hc;

endmodule

// ===== sv/m3e_ema.sv =====
module m3e_ema
    import m3e_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  sample_t sample,
    input  cfg_t    cfg,
    output value_t  average
);

    // The oldest window entry is shifted out before it is ever compared,
    // so only the two newest samples are kept.
    sample_t win1_reg, win2_reg;
    sample_t win1_next, win2_next;
    logic    primed_reg, primed_next;
    value_t  average_reg, average_next;

    sample_t                    median;
    sample_t                    x_sel;
    value_t                     x_q;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [WIDE_W-1:0]   sum;

    // Window after the shift: oldest two survivors plus the new sample
    m3e_median u_median (
        .a   (win1_reg),
        .b   (win2_reg),
        .c   (sample),
        .mid (median)
    );

    assign x_sel   = cfg.median_enable ? median : sample;
    assign x_q     = sample_to_value(x_sel);
    assign diff    = {x_q[VALUE_W-1], x_q} - {average_reg[VALUE_W-1], average_reg};
    assign gain_s  = {1'b0, cfg.smoothing_gain};
    assign prod    = diff * gain_s;
    assign prod_sh = prod >>> GAIN_FRAC_BITS;
    assign sum     = {{(WIDE_W-VALUE_W){average_reg[VALUE_W-1]}}, average_reg}
                   + {{(WIDE_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh};

    always_comb begin
        win1_next    = win1_reg;
        win2_next    = win2_reg;
        primed_next  = primed_reg;
        average_next = average_reg;
        if (step_en) begin
            primed_next = 1'b1;
            if (!primed_reg) begin
                // first sample fills the window and seeds the average
                win1_next    = sample;
                win2_next    = sample;
                average_next = sample_to_value(sample);
            end else begin
                win1_next    = win2_reg;
                win2_next    = sample;
                average_next = sat_value(sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win1_reg    <= '0;
            win2_reg    <= '0;
            primed_reg  <= 1'b0;
            average_reg <= '0;
        end else begin
            win1_reg    <= win1_next;
            win2_reg    <= win2_next;
            primed_reg  <= primed_next;
            average_reg <= average_next;
        end
    end

    assign average = average_reg;

endmodule

// ===== sv/m3e_checker.sv =====
module m3e_checker
    import m3e_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Empty output stage never backpressures the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // An input transfer followed by m_tready shows as a valid result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after transfer");

endmodule

bind median3_ema_filter m3e_checker u_m3e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
